// File: rtl/core/rotated_box_circle_collision_core_defines.svh
// assertion macros shared by the collision core
`ifndef ROTATED_BOX_CIRCLE_COLLISION_CORE_DEFINES_SVH
`define ROTATED_BOX_CIRCLE_COLLISION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RBCC_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rbcc assertion failed");
// next-cycle implication
`define RBCC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rbcc assertion failed");
`else
`define RBCC_ASSERT_IMPL(name, pre, post)
`define RBCC_ASSERT_NEXT(name, pre, post)
`endif

`endif

// File: rtl/core/rbcc_pkg.sv
`default_nettype none
package rbcc_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int RAD_W   = COORD_W - 1;
  localparam int PUSH_W  = 16;

  // cordic datapath
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // internal widths
  localparam int DX_W    = COORD_W + 1;
  localparam int TRIG_W  = 26;
  localparam int NORM_W  = 30;
  localparam int SQ_W    = 2 * NORM_W + 1;
  localparam int ROOT_W  = 31;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int QUO_W   = 15;
  localparam int DREM_W  = NORM_W + QUO_W + 1;

  localparam int UNIT_Q14 = 16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_center_x;
    logic signed [COORD_W-1:0] box_center_y;
    logic        [ANGLE_W-1:0] box_angle;
    logic signed [COORD_W-1:0] disc_center_x;
    logic signed [COORD_W-1:0] disc_center_y;
    logic        [RAD_W-1:0]   disc_radius;
  } query_t;

  typedef struct packed {
    logic                     hit;
    logic signed [PUSH_W-1:0] push_x;
    logic signed [PUSH_W-1:0] push_y;
  } result_t;

  // item data riding along the cordic row
  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [1:0]             quad;
    logic [RAD_W-1:0]       rad;
  } cside_t;

  // item data riding along the square root row
  typedef struct packed {
    logic [NORM_W-1:0]        nax;
    logic [NORM_W-1:0]        nay;
    logic                     hit;
    logic                     pv;
    logic                     sgx;
    logic                     sgy;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } qside_t;

  // item data riding along the divider row
  typedef struct packed {
    logic                     hit;
    logic                     pv;
    logic                     sgx;
    logic                     sgy;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } dside_t;

  // arctangent of 2^-step as a 32-bit binary angle
  function automatic logic [CORDIC_W-1:0] arc_angle(input int step);
    unique case (step)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rbcc_cordic_cell.sv
`default_nettype none
module rbcc_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [rbcc_pkg::CORDIC_W-1:0]  in_x,
  input  logic signed [rbcc_pkg::CORDIC_W-1:0]  in_y,
  input  logic signed [rbcc_pkg::CORDIC_W-1:0]  in_z,
  input  logic        [SIDE_W-1:0]              in_side,
  output logic                                  out_valid,
  output logic signed [rbcc_pkg::CORDIC_W-1:0]  out_x,
  output logic signed [rbcc_pkg::CORDIC_W-1:0]  out_y,
  output logic signed [rbcc_pkg::CORDIC_W-1:0]  out_z,
  output logic        [SIDE_W-1:0]              out_side
);

  localparam logic signed [rbcc_pkg::CORDIC_W-1:0] ARC = rbcc_pkg::arc_angle(STEP);

  logic signed [rbcc_pkg::CORDIC_W-1:0] xs;
  logic signed [rbcc_pkg::CORDIC_W-1:0] ys;

  // floor shifts of this step
  assign xs = in_x >>> STEP;
  assign ys = in_y >>> STEP;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // one micro-rotation toward zero residual angle
  always_ff @(posedge clk) begin
    if (!in_z[rbcc_pkg::CORDIC_W-1]) begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - ARC;
    end else begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + ARC;
    end
    out_side <= in_side;
  end

endmodule
`default_nettype wire

// File: rtl/core/rbcc_sqrt_cell.sv
`default_nettype none
module rbcc_sqrt_cell #(
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [rbcc_pkg::SQ_W-1:0]       in_rem,
  input  logic [rbcc_pkg::ROOT_W-1:0]     in_root,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [rbcc_pkg::SQ_W-1:0]       out_rem,
  output logic [rbcc_pkg::ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int RW = rbcc_pkg::SQ_W;
  localparam int QW = rbcc_pkg::ROOT_W;

  logic [RW+1:0] test;
  logic          fit;

  // (root + 2^bit)^2 - root^2
  assign test = ({{(RW+2-QW){1'b0}}, in_root} << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));
  assign fit  = {2'b00, in_rem} >= test;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // decide one root bit
  always_ff @(posedge clk) begin
    if (fit) begin
      out_rem  <= in_rem - test[RW-1:0];
      out_root <= in_root | (QW'(1) << BIT);
    end else begin
      out_rem  <= in_rem;
      out_root <= in_root;
    end
    out_side <= in_side;
  end

endmodule
`default_nettype wire

// File: rtl/core/rbcc_div_cell.sv
`default_nettype none
module rbcc_div_cell #(
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rbcc_pkg::DREM_W-1:0]   in_rem_x,
  input  logic [rbcc_pkg::DREM_W-1:0]   in_rem_y,
  input  logic [rbcc_pkg::DEN_W-1:0]    in_den,
  input  logic [rbcc_pkg::QUO_W-1:0]    in_qx,
  input  logic [rbcc_pkg::QUO_W-1:0]    in_qy,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [rbcc_pkg::DREM_W-1:0]   out_rem_x,
  output logic [rbcc_pkg::DREM_W-1:0]   out_rem_y,
  output logic [rbcc_pkg::DEN_W-1:0]    out_den,
  output logic [rbcc_pkg::QUO_W-1:0]    out_qx,
  output logic [rbcc_pkg::QUO_W-1:0]    out_qy,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int RW = rbcc_pkg::DREM_W;
  localparam int DW = rbcc_pkg::DEN_W;
  localparam int QW = rbcc_pkg::QUO_W;

  logic [RW:0] trial;
  logic        fx;
  logic        fy;

  // shifted divisor for this quotient bit
  assign trial = {{(RW+1-DW){1'b0}}, in_den} << BIT;
  assign fx    = {1'b0, in_rem_x} >= trial;
  assign fy    = {1'b0, in_rem_y} >= trial;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // restoring step on both axes
  always_ff @(posedge clk) begin
    out_rem_x <= fx ? in_rem_x - trial[RW-1:0] : in_rem_x;
    out_rem_y <= fy ? in_rem_y - trial[RW-1:0] : in_rem_y;
    out_qx    <= fx ? (in_qx | (QW'(1) << BIT)) : in_qx;
    out_qy    <= fy ? (in_qy | (QW'(1) << BIT)) : in_qy;
    out_den   <= in_den;
    out_side  <= in_side;
  end

endmodule
`default_nettype wire

// File: rtl/core/rotated_box_circle_collision_core.sv
`default_nettype none
// throughput: one query per cycle; busy is low whenever rst is low
// the depth is set by the 20 cordic cells, 31 square root cells and 15 divider cells
// the receiver cannot stall: each result is on the ports for exactly one cycle
// rst (synchronous, active high) empties the pipeline and sets box_side to 16384
module rotated_box_circle_collision_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rbcc_pkg::query_t                query,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbcc_pkg::RAD_W-1:0]      cfg_data,
  output logic                            done,
  output rbcc_pkg::result_t               result
);

  `include "rotated_box_circle_collision_core_defines.svh"

  localparam int C_W     = rbcc_pkg::COORD_W;
  localparam int A_W     = rbcc_pkg::ANGLE_W;
  localparam int R_W     = rbcc_pkg::RAD_W;
  localparam int DX_W    = rbcc_pkg::DX_W;
  localparam int T_W     = rbcc_pkg::TRIG_W;
  localparam int K_W     = rbcc_pkg::CORDIC_W;
  localparam int N_STEPS = rbcc_pkg::CORDIC_STEPS;
  localparam int PROD_W  = T_W + DX_W;
  localparam int LSUM_W  = PROD_W + 1;
  localparam int LOC_SH  = 23;
  localparam int LOC_W   = LSUM_W - LOC_SH;
  localparam int OFF_W   = LOC_W + 1;
  localparam int BR_W    = C_W;
  localparam int BSQ_W   = 2 * BR_W;
  localparam int NM_W    = rbcc_pkg::NORM_W;
  localparam int SH_W    = 5;
  localparam int NSQ_W   = 2 * NM_W;
  localparam int SQ_W    = rbcc_pkg::SQ_W;
  localparam int RT_W    = rbcc_pkg::ROOT_W;
  localparam int DEN_W   = rbcc_pkg::DEN_W;
  localparam int QU_W    = rbcc_pkg::QUO_W;
  localparam int DR_W    = rbcc_pkg::DREM_W;
  localparam int NRM_W   = QU_W + 1;
  localparam int BP_W    = T_W + NRM_W;
  localparam int BS_W    = BP_W + 1;
  localparam int W_SH    = 24;
  localparam int W_W     = BS_W - W_SH;
  localparam int P_W     = rbcc_pkg::PUSH_W;
  localparam int NORM_TOP = NM_W - 1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [LSUM_W-1:0] LOC_HALF = LSUM_W'(1) << (LOC_SH - 1);
  localparam logic signed [BS_W-1:0]   W_HALF   = BS_W'(1) << (W_SH - 1);
  localparam logic signed [W_W-1:0]    W_MAX    = W_W'(rbcc_pkg::UNIT_Q14);
  localparam logic signed [W_W-1:0]    W_MIN    = -W_W'(rbcc_pkg::UNIT_Q14);

  localparam int CS_W = $bits(rbcc_pkg::cside_t);
  localparam int QS_W = $bits(rbcc_pkg::qside_t);
  localparam int DS_W = $bits(rbcc_pkg::dside_t);

  logic accept;
  logic [R_W-1:0] box_side;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_side <= R_W'(16384);
    end else if (cfg_valid && cfg_ready) begin
      box_side <= cfg_data;
    end
  end

  // ---------------- input stage ----------------
  logic                  v0;
  logic signed [K_W-1:0] z0;
  rbcc_pkg::cside_t      side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
  end

  // offset of the disc center and angle split into quadrant and residual
  always_ff @(posedge clk) begin
    side0.dx   <= DX_W'(query.disc_center_x) - DX_W'(query.box_center_x);
    side0.dy   <= DX_W'(query.disc_center_y) - DX_W'(query.box_center_y);
    side0.quad <= query.box_angle[A_W-1 -: 2];
    side0.rad  <= query.disc_radius;
    z0         <= {2'b00, query.box_angle[A_W-3:0], {(K_W-A_W){1'b0}}};
  end

  // ---------------- cordic row ----------------
  logic                  cv [0:N_STEPS];
  logic signed [K_W-1:0] cx [0:N_STEPS];
  logic signed [K_W-1:0] cy [0:N_STEPS];
  logic signed [K_W-1:0] cz [0:N_STEPS];
  rbcc_pkg::cside_t      cs [0:N_STEPS];

  assign cv[0] = v0;
  assign cx[0] = rbcc_pkg::CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign cs[0] = side0;

  for (genvar i = 0; i < N_STEPS; i++) begin : g_cordic
    rbcc_cordic_cell #(
      .STEP   (i),
      .SIDE_W (CS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_side   (cs[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_side  (cs[i+1])
    );
  end

  // ---------------- quadrant map and rounding ----------------
  logic signed [K_W:0] xw;
  logic signed [K_W:0] yw;
  logic signed [K_W:0] ccw;
  logic signed [K_W:0] ssw;
  logic signed [K_W:0] crnd;
  logic signed [K_W:0] srnd;

  assign xw = (K_W+1)'(cx[N_STEPS]);
  assign yw = (K_W+1)'(cy[N_STEPS]);

  always_comb begin
    unique case (cs[N_STEPS].quad)
      QUAD_0: begin ccw = xw;  ssw = yw;  end
      QUAD_1: begin ccw = -yw; ssw = xw;  end
      QUAD_2: begin ccw = -xw; ssw = -yw; end
      QUAD_3: begin ccw = yw;  ssw = -xw; end
      default: begin ccw = xw; ssw = yw; end
    endcase
  end

  assign crnd = ccw + (K_W+1)'(32);
  assign srnd = ssw + (K_W+1)'(32);

  logic                   v1;
  logic signed [T_W-1:0]  c1;
  logic signed [T_W-1:0]  s1;
  logic signed [DX_W-1:0] dx1;
  logic signed [DX_W-1:0] dy1;
  logic [R_W-1:0]         rad1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cv[N_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    c1   <= crnd[T_W+5:6];
    s1   <= srnd[T_W+5:6];
    dx1  <= cs[N_STEPS].dx;
    dy1  <= cs[N_STEPS].dy;
    rad1 <= cs[N_STEPS].rad;
  end

  // ---------------- rotate offset into box frame ----------------
  logic                     v2;
  logic signed [PROD_W-1:0] p_cdx;
  logic signed [PROD_W-1:0] p_sdy;
  logic signed [PROD_W-1:0] p_cdy;
  logic signed [PROD_W-1:0] p_sdx;
  logic signed [T_W-1:0]    c2;
  logic signed [T_W-1:0]    s2;
  logic [R_W-1:0]           rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p_cdx <= c1 * dx1;
    p_sdy <= s1 * dy1;
    p_cdy <= c1 * dy1;
    p_sdx <= s1 * dx1;
    c2    <= c1;
    s2    <= s1;
    rad2  <= rad1;
  end

  logic signed [LSUM_W-1:0] lsx;
  logic signed [LSUM_W-1:0] lsy;

  assign lsx = LSUM_W'(p_cdx) + LSUM_W'(p_sdy) + LOC_HALF;
  assign lsy = LSUM_W'(p_cdy) - LSUM_W'(p_sdx) + LOC_HALF;

  logic                    v3;
  logic signed [LOC_W-1:0] lx3;
  logic signed [LOC_W-1:0] ly3;
  logic signed [T_W-1:0]   c3;
  logic signed [T_W-1:0]   s3;
  logic [R_W-1:0]          rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    lx3  <= lsx[LSUM_W-1:LOC_SH];
    ly3  <= lsy[LSUM_W-1:LOC_SH];
    c3   <= c2;
    s3   <= s2;
    rad3 <= rad2;
  end

  // ---------------- clamp to the box ----------------
  logic signed [OFF_W-1:0] half;
  logic signed [OFF_W-1:0] lxe;
  logic signed [OFF_W-1:0] lye;
  logic signed [OFF_W-1:0] clx;
  logic signed [OFF_W-1:0] cly;
  logic signed [OFF_W-1:0] ex;
  logic signed [OFF_W-1:0] ey;

  assign half = OFF_W'(box_side);
  assign lxe  = OFF_W'(lx3);
  assign lye  = OFF_W'(ly3);
  assign clx  = (lxe > half) ? half : ((lxe < -half) ? -half : lxe);
  assign cly  = (lye > half) ? half : ((lye < -half) ? -half : lye);
  assign ex   = lxe - clx;
  assign ey   = lye - cly;

  logic                  v4;
  logic [OFF_W-1:0]      ax4;
  logic [OFF_W-1:0]      ay4;
  logic                  sgx4;
  logic                  sgy4;
  logic [BR_W-1:0]       br4;
  logic signed [T_W-1:0] c4;
  logic signed [T_W-1:0] s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ax4  <= ex[OFF_W-1] ? -ex : ex;
    ay4  <= ey[OFF_W-1] ? -ey : ey;
    sgx4 <= ex[OFF_W-1];
    sgy4 <= ey[OFF_W-1];
    br4  <= {rad3, 1'b0};
    c4   <= c3;
    s4   <= s3;
  end

  // ---------------- squared distance ----------------
  logic                  v5;
  logic                  inr5;
  logic [BSQ_W-1:0]      sqx5;
  logic [BSQ_W-1:0]      sqy5;
  logic [BSQ_W-1:0]      sqr5;
  logic [BR_W-1:0]       ax5;
  logic [BR_W-1:0]       ay5;
  logic                  sgx5;
  logic                  sgy5;
  logic signed [T_W-1:0] c5;
  logic signed [T_W-1:0] s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    inr5 <= (ax4 <= OFF_W'(br4)) && (ay4 <= OFF_W'(br4));
    sqx5 <= ax4[BR_W-1:0] * ax4[BR_W-1:0];
    sqy5 <= ay4[BR_W-1:0] * ay4[BR_W-1:0];
    sqr5 <= br4 * br4;
    ax5  <= ax4[BR_W-1:0];
    ay5  <= ay4[BR_W-1:0];
    sgx5 <= sgx4;
    sgy5 <= sgy4;
    c5   <= c4;
    s5   <= s4;
  end

  // ---------------- hit decision and leading one search ----------------
  logic [BR_W-1:0] m5;
  logic [SH_W-1:0] msb5;

  assign m5 = (ax5 > ay5) ? ax5 : ay5;

  always_comb begin
    msb5 = '0;
    for (int i = 0; i < BR_W; i++) begin
      if (m5[i]) begin
        msb5 = SH_W'(i);
      end
    end
  end

  logic                  v6;
  logic                  hit6;
  logic                  pv6;
  logic [SH_W-1:0]       sh6;
  logic [BR_W-1:0]       ax6;
  logic [BR_W-1:0]       ay6;
  logic                  sgx6;
  logic                  sgy6;
  logic signed [T_W-1:0] c6;
  logic signed [T_W-1:0] s6;
  logic                  hit5;

  assign hit5 = inr5 && (({1'b0, sqx5} + {1'b0, sqy5}) <= {1'b0, sqr5});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    hit6 <= hit5;
    pv6  <= hit5 && ((ax5 | ay5) != '0);
    sh6  <= SH_W'(NORM_TOP) - msb5;
    ax6  <= ax5;
    ay6  <= ay5;
    sgx6 <= sgx5;
    sgy6 <= sgy5;
    c6   <= c5;
    s6   <= s5;
  end

  // ---------------- normalize ----------------
  logic                  v7;
  logic                  hit7;
  logic                  pv7;
  logic [NM_W-1:0]       nax7;
  logic [NM_W-1:0]       nay7;
  logic                  sgx7;
  logic                  sgy7;
  logic signed [T_W-1:0] c7;
  logic signed [T_W-1:0] s7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    nax7 <= NM_W'(ax6) << sh6;
    nay7 <= NM_W'(ay6) << sh6;
    hit7 <= hit6;
    pv7  <= pv6;
    sgx7 <= sgx6;
    sgy7 <= sgy6;
    c7   <= c6;
    s7   <= s6;
  end

  // ---------------- squares of the normalized offset ----------------
  logic             v8;
  logic [NSQ_W-1:0] nsx8;
  logic [NSQ_W-1:0] nsy8;
  rbcc_pkg::qside_t qs8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    nsx8    <= nax7 * nax7;
    nsy8    <= nay7 * nay7;
    qs8.nax <= nax7;
    qs8.nay <= nay7;
    qs8.hit <= hit7;
    qs8.pv  <= pv7;
    qs8.sgx <= sgx7;
    qs8.sgy <= sgy7;
    qs8.c   <= c7;
    qs8.s   <= s7;
  end

  logic             v9;
  logic [SQ_W-1:0]  sum9;
  rbcc_pkg::qside_t qs9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    sum9 <= {1'b0, nsx8} + {1'b0, nsy8};
    qs9  <= qs8;
  end

  // ---------------- square root row ----------------
  logic             qv    [0:RT_W];
  logic [SQ_W-1:0]  qrem  [0:RT_W];
  logic [RT_W-1:0]  qroot [0:RT_W];
  rbcc_pkg::qside_t qsd   [0:RT_W];

  assign qv[0]    = v9;
  assign qrem[0]  = sum9;
  assign qroot[0] = '0;
  assign qsd[0]   = qs9;

  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    rbcc_sqrt_cell #(
      .BIT    (RT_W - 1 - j),
      .SIDE_W (QS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (qv[j]),
      .in_rem    (qrem[j]),
      .in_root   (qroot[j]),
      .in_side   (qsd[j]),
      .out_valid (qv[j+1]),
      .out_rem   (qrem[j+1]),
      .out_root  (qroot[j+1]),
      .out_side  (qsd[j+1])
    );
  end

  // ---------------- divider setup ----------------
  logic             v10;
  logic [DR_W-1:0]  nx10;
  logic [DR_W-1:0]  ny10;
  logic [DEN_W-1:0] den10;
  rbcc_pkg::dside_t ds10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= qv[RT_W];
    end
  end

  // dividend |e| * 2^15 + len over divisor 2 * len rounds half up
  always_ff @(posedge clk) begin
    nx10     <= {1'b0, qsd[RT_W].nax, {QU_W{1'b0}}} + DR_W'(qroot[RT_W]);
    ny10     <= {1'b0, qsd[RT_W].nay, {QU_W{1'b0}}} + DR_W'(qroot[RT_W]);
    den10    <= {qroot[RT_W], 1'b0};
    ds10.hit <= qsd[RT_W].hit;
    ds10.pv  <= qsd[RT_W].pv;
    ds10.sgx <= qsd[RT_W].sgx;
    ds10.sgy <= qsd[RT_W].sgy;
    ds10.c   <= qsd[RT_W].c;
    ds10.s   <= qsd[RT_W].s;
  end

  // ---------------- divider row ----------------
  logic             dv   [0:QU_W];
  logic [DR_W-1:0]  drx  [0:QU_W];
  logic [DR_W-1:0]  dry  [0:QU_W];
  logic [DEN_W-1:0] dden [0:QU_W];
  logic [QU_W-1:0]  dqx  [0:QU_W];
  logic [QU_W-1:0]  dqy  [0:QU_W];
  rbcc_pkg::dside_t dsd  [0:QU_W];

  assign dv[0]   = v10;
  assign drx[0]  = nx10;
  assign dry[0]  = ny10;
  assign dden[0] = den10;
  assign dqx[0]  = '0;
  assign dqy[0]  = '0;
  assign dsd[0]  = ds10;

  for (genvar k = 0; k < QU_W; k++) begin : g_div
    rbcc_div_cell #(
      .BIT    (QU_W - 1 - k),
      .SIDE_W (DS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[k]),
      .in_rem_x  (drx[k]),
      .in_rem_y  (dry[k]),
      .in_den    (dden[k]),
      .in_qx     (dqx[k]),
      .in_qy     (dqy[k]),
      .in_side   (dsd[k]),
      .out_valid (dv[k+1]),
      .out_rem_x (drx[k+1]),
      .out_rem_y (dry[k+1]),
      .out_den   (dden[k+1]),
      .out_qx    (dqx[k+1]),
      .out_qy    (dqy[k+1]),
      .out_side  (dsd[k+1])
    );
  end

  // ---------------- rotate normal back to world axes ----------------
  logic signed [NRM_W-1:0] nxs;
  logic signed [NRM_W-1:0] nys;

  assign nxs = dsd[QU_W].sgx ? -NRM_W'(dqx[QU_W]) : NRM_W'(dqx[QU_W]);
  assign nys = dsd[QU_W].sgy ? -NRM_W'(dqy[QU_W]) : NRM_W'(dqy[QU_W]);

  logic                   v11;
  logic                   hit11;
  logic                   pv11;
  logic signed [BP_W-1:0] pcn;
  logic signed [BP_W-1:0] psn;
  logic signed [BP_W-1:0] pcm;
  logic signed [BP_W-1:0] psm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= dv[QU_W];
    end
  end

  always_ff @(posedge clk) begin
    pcn   <= dsd[QU_W].c * nxs;
    psn   <= dsd[QU_W].s * nys;
    psm   <= dsd[QU_W].s * nxs;
    pcm   <= dsd[QU_W].c * nys;
    hit11 <= dsd[QU_W].hit;
    pv11  <= dsd[QU_W].pv;
  end

  // ---------------- round, clamp, negate ----------------
  logic signed [BS_W-1:0] bsx;
  logic signed [BS_W-1:0] bsy;
  logic signed [W_W-1:0]  wx;
  logic signed [W_W-1:0]  wy;
  logic signed [W_W-1:0]  wxc;
  logic signed [W_W-1:0]  wyc;
  logic signed [W_W-1:0]  pushx_w;
  logic signed [W_W-1:0]  pushy_w;

  assign bsx     = BS_W'(pcn) - BS_W'(psn) + W_HALF;
  assign bsy     = BS_W'(psm) + BS_W'(pcm) + W_HALF;
  assign wx      = bsx[BS_W-1:W_SH];
  assign wy      = bsy[BS_W-1:W_SH];
  assign wxc     = (wx > W_MAX) ? W_MAX : ((wx < W_MIN) ? W_MIN : wx);
  assign wyc     = (wy > W_MAX) ? W_MAX : ((wy < W_MIN) ? W_MIN : wy);
  assign pushx_w = -wxc;
  assign pushy_w = -wyc;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v11;
    end
  end

  always_ff @(posedge clk) begin
    result.hit    <= hit11;
    result.push_x <= pv11 ? pushx_w[P_W-1:0] : '0;
    result.push_y <= pv11 ? pushy_w[P_W-1:0] : '0;
  end

  // ---------------- checks ----------------
  `RBCC_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, box_side == $past(cfg_data))
  `RBCC_ASSERT_IMPL(a_miss_no_push, done && !result.hit, result.push_x == 0 && result.push_y == 0)
  `RBCC_ASSERT_IMPL(a_push_x_bound, done, result.push_x <= 16384 && result.push_x >= -16384)
  `RBCC_ASSERT_IMPL(a_push_y_bound, done, result.push_y <= 16384 && result.push_y >= -16384)

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH  = 79;
  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  rbcc_pkg::query_t query;
  logic cfg_valid;
  logic cfg_ready;
  logic [rbcc_pkg::RAD_W-1:0] cfg_data;
  logic done;
  rbcc_pkg::result_t result;

  // shadow of the box side register
  logic [rbcc_pkg::RAD_W-1:0] side_shadow;
  rbcc_pkg::result_t expected_results[$];
  int errors;
  int idle_pct;
  int stall_cycles;

  localparam longint ARC [20] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  rotated_box_circle_collision_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cordic sine and cosine in q2.24
  function automatic void box_trig(input logic [rbcc_pkg::ANGLE_W-1:0] ang,
                                   output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, xs, ys, cc, ss;
    a = {ang, 16'b0};
    z = longint'(a[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARC[i];
      end else begin
        x += ys; y -= xs; z += ARC[i];
      end
    end
    case (a[31:30])
      2'd0: begin cc = x;  ss = y;  end
      2'd1: begin cc = -y; ss = x;  end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = rnd_shift(cc, 6);
    s = rnd_shift(ss, 6);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected collision result for one query
  function automatic rbcc_pkg::result_t predict_collision(rbcc_pkg::query_t q,
                                                          logic [rbcc_pkg::RAD_W-1:0] side);
    longint c, s, dx, dy, lx, ly, ex, ey, half, nx, ny, wx, wy;
    logic [63:0] ax, ay, big_r, r2, sx, m, len;
    rbcc_pkg::result_t r;
    r = '0;
    box_trig(q.box_angle, c, s);
    dx = longint'(q.disc_center_x) - longint'(q.box_center_x);
    dy = longint'(q.disc_center_y) - longint'(q.box_center_y);
    half = longint'(side);
    big_r = 64'(q.disc_radius) * 2;
    lx = rnd_shift(c * dx + s * dy, 23);
    ly = rnd_shift(c * dy - s * dx, 23);
    ex = lx - clip(lx, -half, half);
    ey = ly - clip(ly, -half, half);
    ax = ex < 0 ? -ex : ex;
    ay = ey < 0 ? -ey : ey;
    if (ax <= big_r && ay <= big_r) begin
      r2 = big_r * big_r;
      sx = ax * ax;
      if (sx <= r2 && ay * ay <= r2 - sx) r.hit = 1'b1;
    end
    if (r.hit && (ax | ay) != 0) begin
      m = ax > ay ? ax : ay;
      while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
      while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
      len = int_sqrt(ax * ax + ay * ay);
      nx = longint'((ax * 2 * 16384 + len) / (2 * len));
      ny = longint'((ay * 2 * 16384 + len) / (2 * len));
      if (ex < 0) nx = -nx;
      if (ey < 0) ny = -ny;
      wx = clip(rnd_shift(c * nx - s * ny, 24), -16384, 16384);
      wy = clip(rnd_shift(s * nx + c * ny, 24), -16384, 16384);
      r.push_x = 16'(-wx);
      r.push_y = 16'(-wy);
    end
    return r;
  endfunction

  // compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    rbcc_pkg::result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.hit !== exp_r.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, result.hit);
          errors++;
        end
        if (result.push_x !== exp_r.push_x) begin
          $display("%0t: push_x expected %0d actual %0d", $time, exp_r.push_x,
                   result.push_x);
          errors++;
        end
        if (result.push_y !== exp_r.push_y) begin
          $display("%0t: push_y expected %0d actual %0d", $time, exp_r.push_y,
                   result.push_y);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // send one query item and record its expected result
  task automatic send_query(rbcc_pkg::query_t q);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    query <= q;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_collision(q, side_shadow));
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic write_side(logic [rbcc_pkg::RAD_W-1:0] v);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_shadow = v;
  endtask

  function automatic rbcc_pkg::query_t make_query(longint bx, longint by, logic [15:0] ang,
                                                  longint dx, longint dy, longint r);
    rbcc_pkg::query_t q;
    q.box_center_x = rbcc_pkg::COORD_W'(bx);
    q.box_center_y = rbcc_pkg::COORD_W'(by);
    q.box_angle = ang;
    q.disc_center_x = rbcc_pkg::COORD_W'(bx + dx);
    q.disc_center_y = rbcc_pkg::COORD_W'(by + dy);
    q.disc_radius = rbcc_pkg::RAD_W'(r);
    return q;
  endfunction

  // extremes, cardinal angles, inside, edge and far cases
  task automatic test_directed();
    send_query(make_query(0, 0, 16'd0, 0, 0, 0));
    send_query(make_query(0, 0, 16'd0, 4096, 0, 0));
    send_query(make_query(0, 0, 16'd0, 8192, 0, 4096));
    send_query(make_query(0, 0, 16'd16384, 12000, 3000, 5000));
    send_query(make_query(0, 0, 16'd32768, -12000, -3000, 5000));
    send_query(make_query(0, 0, 16'd49152, 3000, 12000, 5000));
    send_query(make_query(100, -100, 16'd8192, 9000, 9000, 2000));
    send_query(make_query(0, 0, 16'd65535, 10000, 10000, 4000));
    send_query(make_query(0, 0, 16'd0, 100000, 0, 10));
    send_query(make_query(0, 0, 16'd12345, 0, 0, 8388607));
    send_query(make_query(8388607, 8388607, 16'd0, -16777215, -16777215, 8388607));
    send_query(make_query(-8388608, -8388608, 16'd40000, 16777215, 16777215, 8388607));
    send_query(make_query(-8388608, 8388607, 16'd0, 0, 0, 0));
    send_query(make_query(0, 0, 16'd1, 4096, 4096, 1));
  endtask

  // mostly queries near the box with some fully random ones
  task automatic test_random(int count);
    rbcc_pkg::query_t q;
    longint span, r, bx, by;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 30) begin
        q = $bits(rbcc_pkg::query_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
        r = $urandom_range(3) == 0 ? $urandom_range(8388607)
                                   : $urandom_range(side_shadow + 16);
        span = clip(longint'(side_shadow) + r + 64, 64, 4194303);
        bx = $signed($urandom_range(8388607)) - 4194304;
        by = $signed($urandom_range(8388607)) - 4194304;
        q = make_query(bx, by, 16'($urandom),
                       longint'($urandom_range(2 * span)) - span,
                       longint'($urandom_range(2 * span)) - span, r);
      end
      send_query(q);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    query = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 26;
    side_shadow = 23'd16384;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(100);
    write_side(23'd1);
    test_directed();
    test_random(100);
    idle_pct = 72;
    write_side(23'd8388607);
    test_random(100);
    write_side(23'($urandom_range(1, 40000)));
    test_random(100);
    idle_pct = 0;
    write_side(23'($urandom_range(1, 8388607)));
    test_random(100);
    write_side(23'd16384);
    test_random(100);
    drain_pipe();

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
